/* sv/salru_pkg.sv */
`default_nettype none

package salru_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 4;
    localparam int DEF_STAMP_WIDTH  = 32;

    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 64;
    localparam int TOTAL_W     = 32;
    localparam int ACTION_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_BITS    = 2 + 1 + 1 + 3 * TOTAL_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_FETCH  = 2'd3
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SET_BITS   = 2'd0,
        REG_WAYS       = 2'd1,
        REG_BLOCK_BITS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [2:0] ways_in_use;
        logic [5:0] block_bits;
    } cfg_t;

    typedef enum logic {
        BK_IDLE,
        BK_LOOKUP
    } back_state_t;

endpackage

`default_nettype wire

/* sv/salru_front.sv */
`default_nettype none

module salru_front #(
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int ENTRY_W      = 1 + MAX_SET_BITS + salru_pkg::TAG_W
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [salru_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [salru_pkg::ADDR_W-1:0]        s_axis_tdata,
    input  wire logic [salru_pkg::ACTION_W-1:0]      s_axis_tuser,
    output salru_pkg::cfg_t                          cfg,
    output logic                                     push_valid,
    input  wire logic                                push_ready,
    output logic [ENTRY_W-1:0]                       push_data
);
    import salru_pkg::*;

    localparam int SCW_RAW = $clog2(MAX_SET_BITS + 1);
    localparam int SCW     = (SCW_RAW > 3) ? SCW_RAW : 3;
    localparam int SHW     = 7;

    cfg_t                    cfg_reg;
    logic [SCW-1:0]          s_eff;
    logic [ADDR_W-1:0]       shifted;
    logic [MAX_SET_BITS-1:0] set_mask;
    logic [MAX_SET_BITS-1:0] set_idx;
    logic [SHW-1:0]          total_shift;
    logic [TAG_W-1:0]        tag;
    logic                    is_modify;

    assign cfg_ready     = 1'b1;
    assign cfg           = cfg_reg;
    assign s_axis_tready = push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits    <= 3'd0;
            cfg_reg.ways_in_use <= 3'd1;
            cfg_reg.block_bits  <= 6'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SET_BITS:   cfg_reg.set_bits    <= cfg_data[2:0];
                REG_WAYS:       cfg_reg.ways_in_use <= cfg_data[2:0];
                REG_BLOCK_BITS: cfg_reg.block_bits  <= cfg_data[5:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (SCW'(cfg_reg.set_bits) > SCW'(MAX_SET_BITS))
            s_eff = SCW'(MAX_SET_BITS);
        else
            s_eff = SCW'(cfg_reg.set_bits);
        for (int i = 0; i < MAX_SET_BITS; i++)
            set_mask[i] = (SCW'(i) < s_eff);
        shifted     = s_axis_tdata >> cfg_reg.block_bits;
        set_idx     = shifted[MAX_SET_BITS-1:0] & set_mask;
        total_shift = SHW'(cfg_reg.block_bits) + SHW'(s_eff);
        if (total_shift >= SHW'(ADDR_W))
            tag = '0;
        else
            tag = shifted >> s_eff;
        is_modify  = (s_axis_tuser == ACT_MODIFY);
        push_valid = s_axis_tvalid && (s_axis_tuser != ACT_FETCH);
        push_data  = {is_modify, set_idx, tag};
    end

endmodule

`default_nettype wire

/* sv/salru_fifo.sv */
`default_nettype none

module salru_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = salru_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = data_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* sv/salru_back.sv */
`default_nettype none

module salru_back #(
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS,
    parameter int STAMP_WIDTH  = salru_pkg::DEF_STAMP_WIDTH,
    parameter int ENTRY_W      = 1 + MAX_SET_BITS + salru_pkg::TAG_W
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire salru_pkg::cfg_t                    cfg,
    input  wire logic                               q_valid,
    input  wire logic [ENTRY_W-1:0]                 q_data,
    output logic                                    q_pop,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [salru_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import salru_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WIW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCW_RAW  = $clog2(MAX_WAYS + 1);
    localparam int WCW      = (WCW_RAW > 3) ? WCW_RAW : 3;
    localparam int ROW_TW   = MAX_WAYS * TAG_W;
    localparam int ROW_SW   = MAX_WAYS * STAMP_WIDTH;

    logic [ROW_TW-1:0]       tag_mem   [NUM_SETS];
    logic [ROW_SW-1:0]       stamp_mem [NUM_SETS];
    logic [MAX_WAYS-1:0]     valid_reg [NUM_SETS];

    back_state_t             state_reg;
    back_state_t             state_next;
    logic                    rd_en;
    logic                    complete;
    logic                    out_free;

    logic                    item_mod_reg;
    logic [MAX_SET_BITS-1:0] item_set_reg;
    logic [TAG_W-1:0]        item_tag_reg;
    logic [ROW_TW-1:0]       rd_tags_reg;
    logic [ROW_SW-1:0]       rd_stamps_reg;

    logic [STAMP_WIDTH-1:0]  clock_reg;
    logic [STAMP_WIDTH-1:0]  clock_next;
    logic [TOTAL_W-1:0]      hit_total_reg;
    logic [TOTAL_W-1:0]      miss_total_reg;
    logic [TOTAL_W-1:0]      evict_total_reg;
    logic [TOTAL_W-1:0]      hit_total_next;
    logic [TOTAL_W-1:0]      miss_total_next;
    logic [TOTAL_W-1:0]      evict_total_next;
    logic [TOTAL_W:0]        hit_sum;
    logic [TOTAL_W:0]        miss_sum;
    logic [TOTAL_W:0]        evict_sum;

    logic [WCW-1:0]          ways_eff;
    logic [MAX_WAYS-1:0]     in_use;
    logic [MAX_WAYS-1:0]     valid_row;
    logic [MAX_WAYS-1:0]     hit_vec;
    logic                    hit;
    logic [WIW-1:0]          hit_way;
    logic                    inv_found;
    logic [WIW-1:0]          inv_way;
    logic [WIW-1:0]          lru_way;
    logic [STAMP_WIDTH-1:0]  lru_stamp;
    logic [WIW-1:0]          victim;
    logic [WIW-1:0]          target;
    logic                    evict;
    logic [1:0]              hits_now;
    logic [ROW_TW-1:0]       new_tags;
    logic [ROW_SW-1:0]       new_stamps;

    logic                    out_valid_reg;
    logic [1:0]              out_hits_reg;
    logic                    out_missed_reg;
    logic                    out_evicted_reg;
    logic [TOTAL_W-1:0]      out_hit_total_reg;
    logic [TOTAL_W-1:0]      out_miss_total_reg;
    logic [TOTAL_W-1:0]      out_evict_total_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        complete   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    state_next = BK_LOOKUP;
                end
            end
            BK_LOOKUP:
            begin
                if (out_free)
                begin
                    complete   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            item_mod_reg  <= q_data[ENTRY_W-1];
            item_set_reg  <= q_data[TAG_W +: MAX_SET_BITS];
            item_tag_reg  <= q_data[TAG_W-1:0];
            rd_tags_reg   <= tag_mem[q_data[TAG_W +: MAX_SET_BITS]];
            rd_stamps_reg <= stamp_mem[q_data[TAG_W +: MAX_SET_BITS]];
        end
        if (complete)
        begin
            tag_mem[item_set_reg]   <= new_tags;
            stamp_mem[item_set_reg] <= new_stamps;
        end
    end

    always_comb
    begin
        if (cfg.ways_in_use == 3'd0)
            ways_eff = WCW'(1);
        else if (WCW'(cfg.ways_in_use) > WCW'(MAX_WAYS))
            ways_eff = WCW'(MAX_WAYS);
        else
            ways_eff = WCW'(cfg.ways_in_use);

        valid_row = valid_reg[item_set_reg];
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w]  = (WCW'(w) < ways_eff);
            hit_vec[w] = in_use[w] && valid_row[w]
                         && (rd_tags_reg[w*TAG_W +: TAG_W] == item_tag_reg);
        end

        hit       = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (hit_vec[w] && !hit)
            begin
                hit     = 1'b1;
                hit_way = WIW'(w);
            end
            if (in_use[w] && !valid_row[w] && !inv_found)
            begin
                inv_found = 1'b1;
                inv_way   = WIW'(w);
            end
        end

        lru_way   = '0;
        lru_stamp = rd_stamps_reg[STAMP_WIDTH-1:0];
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && (rd_stamps_reg[w*STAMP_WIDTH +: STAMP_WIDTH] < lru_stamp))
            begin
                lru_way   = WIW'(w);
                lru_stamp = rd_stamps_reg[w*STAMP_WIDTH +: STAMP_WIDTH];
            end
        end

        victim     = inv_found ? inv_way : lru_way;
        target     = hit ? hit_way : victim;
        evict      = !hit && valid_row[victim];
        hits_now   = {1'b0, hit} + {1'b0, item_mod_reg};
        clock_next = clock_reg + 1'b1;

        new_tags   = rd_tags_reg;
        new_stamps = rd_stamps_reg;
        new_tags[target*TAG_W +: TAG_W]               = item_tag_reg;
        new_stamps[target*STAMP_WIDTH +: STAMP_WIDTH] = clock_next;

        hit_sum   = {1'b0, hit_total_reg} + (TOTAL_W + 1)'(hits_now);
        miss_sum  = {1'b0, miss_total_reg} + (TOTAL_W + 1)'(!hit);
        evict_sum = {1'b0, evict_total_reg} + (TOTAL_W + 1)'(evict);
        hit_total_next   = hit_sum[TOTAL_W]   ? '1 : hit_sum[TOTAL_W-1:0];
        miss_total_next  = miss_sum[TOTAL_W]  ? '1 : miss_sum[TOTAL_W-1:0];
        evict_total_next = evict_sum[TOTAL_W] ? '1 : evict_sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
                valid_reg[s] <= '0;
            clock_reg       <= '0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (complete)
            begin
                valid_reg[item_set_reg][target] <= 1'b1;
                clock_reg       <= clock_next;
                hit_total_reg   <= hit_total_next;
                miss_total_reg  <= miss_total_next;
                evict_total_reg <= evict_total_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (complete)
        begin
            out_hits_reg        <= hits_now;
            out_missed_reg      <= !hit;
            out_evicted_reg     <= evict;
            out_hit_total_reg   <= hit_total_next;
            out_miss_total_reg  <= miss_total_next;
            out_evict_total_reg <= evict_total_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_evict_total_reg, out_miss_total_reg,
                                        out_hit_total_reg, out_evicted_reg,
                                        out_missed_reg, out_hits_reg});

    a_evict_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_evicted_reg || out_missed_reg))
        else $error("eviction reported without a miss");

    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_hits_reg != 2'd0 || out_missed_reg))
        else $error("result with neither hit nor miss");

    a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        complete |=> (hit_total_reg >= $past(hit_total_reg)))
        else $error("hit total went backward");

    a_pop_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE && q_valid) |=> (state_reg == BK_LOOKUP))
        else $error("queued access not taken into lookup");

endmodule

`default_nettype wire

/* sv/set_assoc_lru_cache_sim_unit.sv */
// Set-associative LRU cache model: counts hits, misses and evictions.
// Channels:
//   cfg_*    register writes (index 0 set_bits, 1 ways_in_use, 2 block_bits);
//            always ready; write only while no access is in flight.
//   s_axis_* one memory access per word: tuser = action, tdata = address.
//            Instruction fetches are taken and dropped without a result.
//   m_axis_* one result per load, store or modify: hit/miss/evict flags and
//            the saturating running totals.
// In the lookup engine, the idle state pops an access and reads the set's
// tag and stamp rows from memory; the lookup state waits until the result
// register is free, compares, picks the victim and writes the row back.
// A new access is taken only after the last one is written back.
// A two-word queue decouples address decode from the lookup engine; a
// stalled m_axis_tready holds the result register, then the engine, then
// the queue, and finally drops s_axis_tready.
// Reset clears all line valid bits, the access clock, the totals and the
// configuration (one set, one way, no offset bits); it takes effect at once.
`default_nettype none

module set_assoc_lru_cache_sim_unit #(
    parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS,
    parameter int STAMP_WIDTH  = salru_pkg::DEF_STAMP_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [salru_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [salru_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [63:0] address
    input  wire logic [salru_pkg::ADDR_W-1:0]       s_axis_tdata,
    // [1:0] action
    input  wire logic [salru_pkg::ACTION_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] hits_now, [2] missed, [3] evicted, [35:4] total_hits,
    // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
    output logic [salru_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import salru_pkg::*;

    localparam int ENTRY_W = 1 + MAX_SET_BITS + TAG_W;

    cfg_t               cfg;
    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_data;

    salru_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    salru_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    salru_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .STAMP_WIDTH  (STAMP_WIDTH),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
